// File: hdl/ctrc_pkg.sv
// ----------------------------------------------------------------------------
// Compact target retarget check: shared package
// Field widths, result codes and the per-stage side record of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ctrc_pkg;

  localparam int MANT_W  = 23;
  localparam int SPAN_W  = 27;
  localparam int PROD_W  = 52;
  localparam int HALF_W  = 26;
  localparam int RECIP_W = 53;
  localparam int DIV_W   = 19;
  localparam int RAW_W   = 33;
  localparam int HASH_W  = 256;

  localparam logic [31:0] MAX_TARGET_RESET = 32'h1e0ffff0;

  localparam logic [1:0] REASON_OK     = 2'd0;
  localparam logic [1:0] REASON_LINK   = 2'd1;
  localparam logic [1:0] REASON_TARGET = 2'd2;
  localparam logic [1:0] REASON_PROOF  = 2'd3;

  typedef struct packed {
    logic [31:0] block_bits;
    logic [31:0] parent_bits;
    logic        known;
    logic        link_ok;
    logic        retarget;
    logic        proof_ok;
  } side_t;

endpackage

`default_nettype wire

// File: hdl/ctrc_retarget.sv
// ----------------------------------------------------------------------------
// Compact target retarget check: retarget datapath
// Clamps the timespan, scales the parent mantissa, divides by the nominal
// span through a reciprocal and renormalizes into compact form. Eight stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrc_retarget #(
  parameter int unsigned TARGET_TIMESPAN = 302400
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [31:0]                parent_bits,
  input  logic [31:0]                parent_time,
  input  logic                       span_start_known,
  input  logic [31:0]                span_start_time,
  output logic [ctrc_pkg::RAW_W-1:0] raw_bits
);

  localparam int MW = ctrc_pkg::MANT_W;
  localparam int SW = ctrc_pkg::SPAN_W;
  localparam int PW = ctrc_pkg::PROD_W;
  localparam int HW = ctrc_pkg::HALF_W;
  localparam int RW = ctrc_pkg::RECIP_W;
  localparam int DW = ctrc_pkg::DIV_W;
  localparam int QW = HW + DW;

  localparam int unsigned SPAN_MIN = TARGET_TIMESPAN / 4;
  localparam int unsigned SPAN_MAX = TARGET_TIMESPAN * 4;
  localparam int unsigned DIVISOR  = TARGET_TIMESPAN >> 6;

  localparam logic signed [32:0] SPAN_LO = 33'(SPAN_MIN);
  localparam logic signed [32:0] SPAN_HI = 33'(SPAN_MAX);
  localparam logic [RW-1:0]      RECIP   = RW'((64'd1 << PW) / DIVISOR);
  localparam logic [DW-1:0]      DIV_V   = DW'(DIVISOR);

  logic signed [32:0] span_diff;
  logic [SW-1:0]      span_c;

  logic [SW+1:0]      s1_span4;
  logic [MW-1:0]      s1_mant;
  logic signed [9:0]  exp_pipe [7];

  logic [PW-1:0]      s2_prod;

  logic [2*HW-1:0]    pp_ll;
  logic [2*HW:0]      pp_lh;
  logic [2*HW-1:0]    pp_hl;
  logic [2*HW:0]      pp_hh;
  logic [PW-1:0]      s3_prod;

  logic [104:0]       prod_full;
  logic [PW-1:0]      s4_q;
  logic [PW-1:0]      s4_prod;

  logic [HW+DW-1:0]   pq_lo;
  logic [HW+DW-1:0]   pq_hi;
  logic [PW-1:0]      s5_q;
  logic [PW-1:0]      s5_prod;

  logic [HW+DW+HW-1:0] qd_full;
  logic [PW-1:0]      s6_qd;
  logic [PW-1:0]      s6_q;
  logic [PW-1:0]      s6_prod;

  logic [PW-1:0]      rem;
  logic               fix;
  logic [PW-1:0]      s7_q;

  logic [2:0]         n_q;
  logic [2:0]         n_e;
  logic [2:0]         n_sh;
  logic [PW-1:0]      q_sh;
  logic signed [9:0]  e_new;

  always_comb begin
    if (span_start_known) begin
      span_diff = $signed({1'b0, parent_time}) - $signed({1'b0, span_start_time});
    end else begin
      span_diff = '0;
    end
    if (span_diff < SPAN_LO) begin
      span_c = SPAN_LO[SW-1:0];
    end else if (span_diff > SPAN_HI) begin
      span_c = SPAN_HI[SW-1:0];
    end else begin
      span_c = span_diff[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_span4    <= {span_c, 2'b00};
      s1_mant     <= parent_bits[MW-1:0];
      exp_pipe[0] <= $signed({2'b00, parent_bits[31:24]}) - 10'sd1;
      for (int k = 1; k < 7; k++) begin
        exp_pipe[k] <= exp_pipe[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_prod <= PW'(s1_mant) * PW'(s1_span4);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll   <= PW'(s2_prod[HW-1:0]) * PW'(RECIP[HW-1:0]);
      pp_lh   <= RW'(s2_prod[HW-1:0]) * RW'(RECIP[RW-1:HW]);
      pp_hl   <= PW'(s2_prod[PW-1:HW]) * PW'(RECIP[HW-1:0]);
      pp_hh   <= RW'(s2_prod[PW-1:HW]) * RW'(RECIP[RW-1:HW]);
      s3_prod <= s2_prod;
    end
  end

  assign prod_full = {pp_hh, 52'd0} + {26'd0, pp_lh, 26'd0} + {27'd0, pp_hl, 26'd0}
                   + {53'd0, pp_ll};

  always_ff @(posedge clk) begin
    if (en) begin
      s4_q    <= prod_full[103:52];
      s4_prod <= s3_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pq_lo   <= QW'(s4_q[HW-1:0]) * QW'(DIV_V);
      pq_hi   <= QW'(s4_q[PW-1:HW]) * QW'(DIV_V);
      s5_q    <= s4_q;
      s5_prod <= s4_prod;
    end
  end

  assign qd_full = {pq_hi, 26'd0} + {26'd0, pq_lo};

  always_ff @(posedge clk) begin
    if (en) begin
      s6_qd   <= qd_full[PW-1:0];
      s6_q    <= s5_q;
      s6_prod <= s5_prod;
    end
  end

  assign rem = s6_prod - s6_qd;
  assign fix = (rem >= {33'd0, DIV_V});

  always_ff @(posedge clk) begin
    if (en) begin
      s7_q <= s6_q + {51'd0, fix};
    end
  end

  always_comb begin
    priority if (s7_q[51:23] == '0) begin
      n_q = 3'd0;
    end else if (s7_q[51:31] == '0) begin
      n_q = 3'd1;
    end else if (s7_q[51:39] == '0) begin
      n_q = 3'd2;
    end else if (s7_q[51:47] == '0) begin
      n_q = 3'd3;
    end else begin
      n_q = 3'd4;
    end
    priority if (exp_pipe[6] == -10'sd1) begin
      n_e = 3'd2;
    end else if (exp_pipe[6] == 10'sd0) begin
      n_e = 3'd1;
    end else begin
      n_e = 3'd0;
    end
    n_sh = (n_q > n_e) ? n_q : n_e;
    unique case (n_sh)
      3'd0:    q_sh = s7_q;
      3'd1:    q_sh = s7_q >> 8;
      3'd2:    q_sh = s7_q >> 16;
      3'd3:    q_sh = s7_q >> 24;
      default: q_sh = s7_q >> 32;
    endcase
    e_new = exp_pipe[6] + $signed({7'd0, n_sh});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw_bits <= {e_new[8:0], 1'b0, q_sh[MW-1:0]};
    end
  end

endmodule

`default_nettype wire

// File: hdl/ctrc_proof.sv
// ----------------------------------------------------------------------------
// Compact target retarget check: proof comparison
// Expands the claimed compact target and compares the hash against it
// in three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrc_proof (
  input  logic                        clk,
  input  logic                        en,
  input  logic [31:0]                 block_bits,
  input  logic [ctrc_pkg::HASH_W-1:0] hash,
  output logic                        proof_ok
);

  localparam int HSW = ctrc_pkg::HASH_W;

  logic [7:0]     exp_v;
  logic [7:0]     sh;
  logic [HSW-1:0] target;

  logic           s1_range;
  logic [HSW-1:0] s1_target;
  logic [HSW-1:0] s1_hash;

  logic           s2_range;
  logic [3:0]     s2_lt;
  logic [3:0]     s2_eq;

  assign exp_v  = block_bits[31:24];
  assign sh     = {5'(exp_v - 8'd3), 3'b000};
  assign target = {233'd0, block_bits[ctrc_pkg::MANT_W-1:0]} << sh;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_range  <= (exp_v >= 8'd3) && (exp_v <= 8'd30);
      s1_target <= target;
      s1_hash   <= hash;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_range <= s1_range;
      for (int w = 0; w < 4; w++) begin
        s2_lt[w] <= s1_hash[64*w +: 64] < s1_target[64*w +: 64];
        s2_eq[w] <= s1_hash[64*w +: 64] == s1_target[64*w +: 64];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      proof_ok <= s2_range && (s2_lt[3] || (s2_eq[3] && (s2_lt[2] || (s2_eq[2]
                  && (s2_lt[1] || (s2_eq[1] && (s2_lt[0] || s2_eq[0])))))));
    end
  end

endmodule

`default_nettype wire

// File: hdl/compact_target_retarget_check.sv
// ----------------------------------------------------------------------------
// Compact target retarget check: top level
// Validates one block header against its predecessor: link and height,
// retarget or carried compact target, and the proof hash against the target.
//
//   Channel  Signals                           Direction
//   input    in_valid, in_stall, header fields in, stall out
//   output   out_valid, out_stall, results     out, stall in
//   config   cfg_valid, cfg_ready, cfg data    in, ready out
//
// A header passes nine stages from input transfer to result; one header can
// enter each cycle unless a stalled result drops the enable all nine share.
// Reset is synchronous, clears the stage valid bits and restores the target
// ceiling to its reset value.
// When a result waits under out_stall, every stage holds and in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module compact_target_retarget_check #(
  parameter int unsigned RETARGET_INTERVAL = 2016,
  parameter int unsigned TARGET_TIMESPAN   = 302400
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] block_height,
  input  logic [31:0] block_bits,
  input  logic        parent_linked,
  input  logic [31:0] parent_height,
  input  logic [31:0] parent_bits,
  input  logic [31:0] parent_time,
  input  logic        span_start_known,
  input  logic [31:0] span_start_time,
  input  logic [63:0] hash_word0,
  input  logic [63:0] hash_word1,
  input  logic [63:0] hash_word2,
  input  logic [63:0] hash_word3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic [1:0]  fail_reason,
  output logic [31:0] expected_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_max_compact_target
);

  localparam logic [32:0] H_RECIP  = 33'((64'd1 << 32) / RETARGET_INTERVAL);
  localparam logic [15:0] INTERVAL = 16'(RETARGET_INTERVAL);

  logic                        en;
  logic [7:0]                  vld;
  ctrc_pkg::side_t             side [8];
  ctrc_pkg::side_t             side_in;
  ctrc_pkg::side_t             side3_in;
  logic [31:0]                 max_target;

  logic [64:0]                 m1_prod;
  logic [31:0]                 m1_h;
  logic [31:0]                 m2_qn;
  logic [31:0]                 m2_h;
  logic [31:0]                 m_rem;
  logic                        ret3;
  logic                        proof3;

  logic [ctrc_pkg::RAW_W-1:0]  raw_bits;
  logic [31:0]                 capped;
  logic [31:0]                 exp_next;
  logic [1:0]                  reason_next;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_target <= ctrc_pkg::MAX_TARGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_target <= cfg_max_compact_target;
    end
  end

  always_comb begin
    side_in             = '0;
    side_in.block_bits  = block_bits;
    side_in.parent_bits = parent_bits;
    side_in.known       = span_start_known;
    side_in.link_ok     = parent_linked && (block_height == parent_height + 32'd1);
  end

  always_comb begin
    side3_in          = side[2];
    side3_in.retarget = ret3;
    side3_in.proof_ok = proof3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[6:0], in_valid};
      out_valid <= vld[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      side[1] <= side[0];
      side[2] <= side[1];
      side[3] <= side3_in;
      for (int k = 4; k < 8; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign m_rem = m2_h - m2_qn;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_prod <= 65'(block_height) * 65'(H_RECIP);
      m1_h    <= block_height;
      m2_qn   <= m1_prod[63:32] * {16'd0, INTERVAL};
      m2_h    <= m1_h;
      ret3    <= (m_rem == 32'd0) || (m_rem == {16'd0, INTERVAL});
    end
  end

  ctrc_proof u_proof (
    .clk        (clk),
    .en         (en),
    .block_bits (block_bits),
    .hash       ({hash_word3, hash_word2, hash_word1, hash_word0}),
    .proof_ok   (proof3)
  );

  ctrc_retarget #(
    .TARGET_TIMESPAN (TARGET_TIMESPAN)
  ) u_retarget (
    .clk              (clk),
    .en               (en),
    .parent_bits      (parent_bits),
    .parent_time      (parent_time),
    .span_start_known (span_start_known),
    .span_start_time  (span_start_time),
    .raw_bits         (raw_bits)
  );

  always_comb begin
    capped   = (raw_bits > {1'b0, max_target}) ? max_target : raw_bits[31:0];
    exp_next = side[7].retarget ? capped : side[7].parent_bits;
    priority if (!side[7].link_ok) begin
      reason_next = ctrc_pkg::REASON_LINK;
    end else if (side[7].retarget ? (side[7].known && side[7].block_bits != exp_next)
                                  : (side[7].block_bits != side[7].parent_bits)) begin
      reason_next = ctrc_pkg::REASON_TARGET;
    end else if (!side[7].proof_ok) begin
      reason_next = ctrc_pkg::REASON_PROOF;
    end else begin
      reason_next = ctrc_pkg::REASON_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      expected_bits <= exp_next;
      fail_reason   <= reason_next;
      accepted      <= (reason_next == ctrc_pkg::REASON_OK);
    end
  end

  a_in_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("Input transfer did not enter the first stage.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> (vld == $past(vld)) && out_valid)
    else $error("Pipeline moved while the output was stalled.");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !vld[7]) |=> !out_valid)
    else $error("Result repeated after its output transfer.");

  a_cfg: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (max_target == $past(cfg_max_compact_target)))
    else $error("Configuration write was lost.");

endmodule

`default_nettype wire

// File: dv/tb_compact_target_retarget_check.sv
// ----------------------------------------------------------------------------
// Compact target retarget check: testbench
// Drives header transfers into the checker with random idle bursts on both
// channels and one long output hold-off, then compares every result against a
// self-contained predictor of the link, retarget and proof checks. The target
// ceiling is rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------

module tb_compact_target_retarget_check;

  localparam int unsigned RETARGET_INTERVAL = 2016;
  localparam int unsigned TARGET_TIMESPAN   = 302400;
  localparam int unsigned DUT_LATENCY       = 9;
  localparam int unsigned HOLD_CYCLES       = 150;
  localparam int unsigned PRINT_CAP         = 100;

  typedef struct {
    logic [31:0]  height;
    logic [31:0]  bits;
    logic         linked;
    logic [31:0]  pheight;
    logic [31:0]  pbits;
    logic [31:0]  ptime;
    logic         known;
    logic [31:0]  stime;
    logic [255:0] hash;
  } header_t;

  typedef struct {
    logic        acc;
    logic [1:0]  reason;
    logic [31:0] bits;
  } verdict_t;

  class retarget_verdicts;
    logic [31:0] ceiling = ctrc_pkg::MAX_TARGET_RESET;
    verdict_t    waiting[$];
    int          errors = 0;

    function logic [31:0] retarget_bits(logic [31:0] pbits, logic [31:0] ptime,
                                        logic known, logic [31:0] stime);
      longint          e;
      longint          span;
      longint unsigned m;
      longint unsigned r;
      e = longint'({56'd0, pbits[31:24]});
      m = {41'd0, pbits[22:0]};
      span = known ? ($signed({32'd0, ptime}) - $signed({32'd0, stime})) : 64'sd0;
      if (span < longint'(TARGET_TIMESPAN / 4)) span = longint'(TARGET_TIMESPAN / 4);
      if (span > longint'(TARGET_TIMESPAN) * 4) span = longint'(TARGET_TIMESPAN) * 4;
      m = m * (64'(span) * 64'd4);
      m = m / 64'(TARGET_TIMESPAN >> 6);
      e = e - 1;
      while (e < 1 || m > 64'h7fffff) begin
        m = m >> 8;
        e = e + 1;
      end
      r = (64'(e) << 24) | m;
      if (r > {32'd0, ceiling}) r = {32'd0, ceiling};
      return r[31:0];
    endfunction

    function logic [255:0] proof_target(logic [31:0] bits);
      if (bits[31:24] < 8'd3 || bits[31:24] > 8'd30) return '0;
      return {233'd0, bits[22:0]} << (8 * (int'(bits[31:24]) - 3));
    endfunction

    function verdict_t predict(header_t h);
      verdict_t v;
      logic     retarget;
      logic     proof_ok;
      retarget = (h.height % RETARGET_INTERVAL) == 32'd0;
      proof_ok = h.bits[31:24] >= 8'd3 && h.bits[31:24] <= 8'd30 &&
                 h.hash <= proof_target(h.bits);
      v.bits = retarget ? retarget_bits(h.pbits, h.ptime, h.known, h.stime) : h.pbits;
      if (!h.linked || h.height != 32'(h.pheight + 32'd1)) v.reason = ctrc_pkg::REASON_LINK;
      else if (retarget ? (h.known && h.bits != v.bits) : (h.bits != h.pbits))
        v.reason = ctrc_pkg::REASON_TARGET;
      else if (!proof_ok) v.reason = ctrc_pkg::REASON_PROOF;
      else v.reason = ctrc_pkg::REASON_OK;
      v.acc = v.reason == ctrc_pkg::REASON_OK;
      return v;
    endfunction

    function void note_header(header_t h);
      waiting.push_back(predict(h));
    endfunction

    task report(string what);
      if (errors < PRINT_CAP) $display("mismatch: %s", what);
      errors++;
    endtask

    task check_verdict(logic acc, logic [1:0] reason, logic [31:0] bits);
      verdict_t v;
      if (waiting.size() == 0) begin
        report("result transfer with no header waiting");
        return;
      end
      v = waiting.pop_front();
      if (acc !== v.acc) report($sformatf("accepted %b, want %b", acc, v.acc));
      if (reason !== v.reason)
        report($sformatf("fail_reason %0d, want %0d", reason, v.reason));
      if (bits !== v.bits)
        report($sformatf("expected_bits %h, want %h", bits, v.bits));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] block_height = '0;
  logic [31:0] block_bits = '0;
  logic        parent_linked = 1'b0;
  logic [31:0] parent_height = '0;
  logic [31:0] parent_bits = '0;
  logic [31:0] parent_time = '0;
  logic        span_start_known = 1'b0;
  logic [31:0] span_start_time = '0;
  logic [63:0] hash_word0 = '0;
  logic [63:0] hash_word1 = '0;
  logic [63:0] hash_word2 = '0;
  logic [63:0] hash_word3 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        accepted;
  logic [1:0]  fail_reason;
  logic [31:0] expected_bits;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_max_compact_target = '0;

  retarget_verdicts sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;

  always #2 clk = ~clk;

  compact_target_retarget_check #(
    .RETARGET_INTERVAL(RETARGET_INTERVAL),
    .TARGET_TIMESPAN(TARGET_TIMESPAN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .block_height(block_height),
    .block_bits(block_bits),
    .parent_linked(parent_linked),
    .parent_height(parent_height),
    .parent_bits(parent_bits),
    .parent_time(parent_time),
    .span_start_known(span_start_known),
    .span_start_time(span_start_time),
    .hash_word0(hash_word0),
    .hash_word1(hash_word1),
    .hash_word2(hash_word2),
    .hash_word3(hash_word3),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .accepted(accepted),
    .fail_reason(fail_reason),
    .expected_bits(expected_bits),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_max_compact_target(cfg_max_compact_target)
  );

  function header_t make_hdr(logic [31:0] height, logic [31:0] bits, logic linked,
                             logic [31:0] pheight, logic [31:0] pbits,
                             logic [31:0] ptime, logic known, logic [31:0] stime,
                             logic [255:0] hash);
    header_t h;
    h.height = height;
    h.bits = bits;
    h.linked = linked;
    h.pheight = pheight;
    h.pbits = pbits;
    h.ptime = ptime;
    h.known = known;
    h.stime = stime;
    h.hash = hash;
    return h;
  endfunction

  task automatic send_header(header_t h);
    in_valid <= 1'b1;
    block_height <= h.height;
    block_bits <= h.bits;
    parent_linked <= h.linked;
    parent_height <= h.pheight;
    parent_bits <= h.pbits;
    parent_time <= h.ptime;
    span_start_known <= h.known;
    span_start_time <= h.stime;
    hash_word0 <= h.hash[63:0];
    hash_word1 <= h.hash[127:64];
    hash_word2 <= h.hash[191:128];
    hash_word3 <= h.hash[255:192];
    do @(posedge clk); while (in_stall);
    sb.note_header(h);
  endtask

  task automatic write_ceiling(logic [31:0] value);
    in_valid <= 1'b0;
    while (sb.waiting.size() != 0) @(posedge clk);
    repeat (DUT_LATENCY + 3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_compact_target <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.ceiling = value;
  endtask

  task automatic run_headers(int count, int hold_at);
    header_t      h;
    logic [255:0] tgt;
    logic [31:0]  delta;
    int unsigned  pick;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (!quiet && !hold_req && hold_left == 0 && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      h = make_hdr($urandom, $urandom, 1'($urandom), $urandom, $urandom, $urandom,
                   1'($urandom), $urandom,
                   {$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        if ($urandom_range(0, 9) < 4)
          h.height = 32'($urandom_range(0, 2130440) * RETARGET_INTERVAL);
        h.linked = 1'b1;
        h.pheight = h.height - 32'd1;
        if ($urandom_range(0, 9) < 6)
          h.pbits = {8'($urandom_range(3, 30)), 1'($urandom), 23'($urandom)};
        h.known = $urandom_range(0, 7) != 0;
        case ($urandom_range(0, 4))
          0: delta = $urandom_range(TARGET_TIMESPAN / 4, TARGET_TIMESPAN * 4);
          1: delta = $urandom_range(0, TARGET_TIMESPAN / 4);
          2: delta = $urandom_range(TARGET_TIMESPAN * 4, 40000000);
          3: delta = -32'($urandom_range(1, 1000000));
          default: delta = $urandom;
        endcase
        h.ptime = h.stime + delta;
        if ((h.height % RETARGET_INTERVAL) == 32'd0)
          h.bits = sb.retarget_bits(h.pbits, h.ptime, h.known, h.stime);
        else
          h.bits = h.pbits;
        if ($urandom_range(0, 19) == 0) h.bits = h.bits ^ (32'd1 << $urandom_range(0, 31));
        if (pick < 15) begin
          if ($urandom_range(0, 1) == 0) h.linked = 1'b0;
          else h.pheight = h.pheight + 32'($urandom_range(1, 3));
        end
        tgt = sb.proof_target(h.bits);
        case ($urandom_range(0, 5))
          0: h.hash = tgt;
          1: h.hash = tgt + 256'd1;
          2: h.hash = tgt - 256'd1;
          3: h.hash = tgt >> $urandom_range(0, 255);
          4: h.hash = '0;
          default: ;
        endcase
      end
      send_header(h);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_verdict(accepted, fail_reason, expected_bits);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [31:0] nb;
    logic [31:0] rb;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_header(make_hdr('0, '0, 1'b0, '0, '0, '0, 1'b0, '0, '0));
    send_header(make_hdr('1, '1, 1'b1, '1, '1, '1, 1'b1, '1, '1));
    nb = sb.retarget_bits(32'h1d00ffff, 32'd1302400, 1'b1, 32'd1000000);
    send_header(make_hdr(32'd0, nb, 1'b1, '1, 32'h1d00ffff, 32'd1302400, 1'b1,
                         32'd1000000, '0));
    send_header(make_hdr(32'd0, nb, 1'b1, '1, 32'h1d00ffff, 32'd1302400, 1'b1,
                         32'd1000000, sb.proof_target(nb)));
    send_header(make_hdr(32'd0, nb, 1'b1, '1, 32'h1d00ffff, 32'd1302400, 1'b1,
                         32'd1000000, sb.proof_target(nb) + 256'd1));
    send_header(make_hdr(32'd0, nb, 1'b0, '1, 32'h1d00ffff, 32'd1302400, 1'b1,
                         32'd1000000, '0));
    send_header(make_hdr(32'd2016, 32'h1c123456, 1'b1, 32'd2015, 32'h1d00ffff,
                         32'd5, 1'b0, 32'd9, '0));
    nb = sb.retarget_bits(32'h1c0fffff, 32'd100, 1'b1, 32'd200);
    send_header(make_hdr(32'd4032, nb, 1'b1, 32'd4031, 32'h1c0fffff, 32'd100, 1'b1,
                         32'd200, '0));
    nb = sb.retarget_bits(32'h1c0fffff, '1, 1'b1, '0);
    send_header(make_hdr(32'd4032, nb, 1'b1, 32'd4031, 32'h1c0fffff, '1, 1'b1, '0, '0));
    send_header(make_hdr(32'd5, 32'h02123456, 1'b1, 32'd4, 32'h02123456, '0, 1'b1,
                         '0, '0));
    send_header(make_hdr(32'd5, 32'h1f00ffff, 1'b1, 32'd4, 32'h1f00ffff, '0, 1'b1,
                         '0, '0));
    send_header(make_hdr(32'd7, 32'h037fffff, 1'b1, 32'd6, 32'h037fffff, '0, 1'b1,
                         '0, 256'h7fffff));
    send_header(make_hdr(32'd7, 32'h1e7fffff, 1'b1, 32'd6, 32'h1e7fffff, '0, 1'b1,
                         '0, '1));
    send_header(make_hdr(32'd7, 32'h1e7fffff, 1'b1, 32'd6, 32'h1e7fffff, '0, 1'b1,
                         '0, '0));
    send_header(make_hdr(32'd8, 32'h1d00fffe, 1'b1, 32'd7, 32'h1d00ffff, '0, 1'b1,
                         '0, '0));
    nb = sb.retarget_bits(32'h1d00ffff, 32'd1302400, 1'b1, 32'd1000000);
    send_header(make_hdr(32'd6048, nb ^ 32'd1, 1'b1, 32'd6047, 32'h1d00ffff,
                         32'd1302400, 1'b1, 32'd1000000, '0));
    rb = 32'h00000001;
    repeat (4) begin
      nb = sb.retarget_bits(rb, 32'd1302400, 1'b1, 32'd1000000);
      send_header(make_hdr(32'd8064, nb, 1'b1, 32'd8063, rb, 32'd1302400, 1'b1,
                           32'd1000000, '0));
      rb = (rb == 32'h00000001) ? 32'h01ffffff :
           (rb == 32'h01ffffff) ? 32'hff7fffff : 32'h1e7fffff;
    end

    write_ceiling('1);
    run_headers(330, -1);
    write_ceiling('0);
    run_headers(330, -1);
    write_ceiling(32'h1d00ffff);
    run_headers(330, 120);
    write_ceiling($urandom);
    run_headers(330, -1);
    write_ceiling(ctrc_pkg::MAX_TARGET_RESET);
    run_headers(330, -1);
    quiet = 1'b1;
    run_headers(200, -1);

    in_valid <= 1'b0;
    for (int n = 0; n < 20000 && sb.waiting.size() != 0; n++) @(posedge clk);
    repeat (DUT_LATENCY + 5) @(posedge clk);
    if (sb.waiting.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.waiting.size()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/ctrc_pkg.sv
hdl/ctrc_retarget.sv
hdl/ctrc_proof.sv
hdl/compact_target_retarget_check.sv
dv/tb_compact_target_retarget_check.sv
